// ===== rtl/graph_dfs_timestamps_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the graph walk block
// Shared wrappers that put every check on the rising clock edge and mute it
// while the synchronous reset is held.
// ----------------------------------------------------------------------------
`ifndef GRAPH_DFS_TIMESTAMPS_MACROS_SVH
`define GRAPH_DFS_TIMESTAMPS_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define GDFS_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A condition in one cycle that forces a consequence in the next.
`define GDFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gdfs_pkg.sv =====
// ----------------------------------------------------------------------------
// gdfs_pkg
// Types and constants shared by the depth-first walk block and its parts.
// ----------------------------------------------------------------------------
`default_nettype none

package gdfs_pkg;

    // Default sizes of the graph store.
    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 256;

    // Node identifiers on the ports are six bits wide.
    localparam int ID_LIMIT = 64;
    localparam int NODE_W   = 6;
    localparam int TIME_W   = 7;
    localparam int COUNT_W  = 7;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 7'd64;

    // Operation codes of an input word.
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APP_RD,
        ST_APP_WR,
        ST_APP_LINK,
        ST_RUN_START,
        ST_SWEEP,
        ST_PUSH,
        ST_STEP,
        ST_NBR,
        ST_POP,
        ST_REP_RD,
        ST_REP_LOAD,
        ST_REP_WAIT
    } gdfs_state_t;

    // Write strobes for the adjacency store.
    typedef struct packed {
        logic list_we;
        logic list_clear;
        logic nbr_we;
        logic link_we;
    } gdfs_adj_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/gdfs_adj.sv =====
// ----------------------------------------------------------------------------
// gdfs_adj
// Adjacency store: list heads and tails per node with valid bits, and the
// link slots holding neighbour identifiers and next pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module gdfs_adj #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  gdfs_pkg::gdfs_adj_ctrl_t           ctrl,
    input  logic [$clog2(MAX_NODES)-1:0]       list_raddr,
    input  logic [$clog2(MAX_NODES)-1:0]       list_waddr,
    input  logic [$clog2(2*MAX_EDGES+1)-1:0]   list_wfirst,
    input  logic [$clog2(2*MAX_EDGES+1)-1:0]   list_wlast,
    output logic                               list_rd_valid,
    output logic [$clog2(2*MAX_EDGES+1)-1:0]   list_rd_first,
    output logic [$clog2(2*MAX_EDGES+1)-1:0]   list_rd_last,
    input  logic [$clog2(2*MAX_EDGES)-1:0]     slot_raddr,
    input  logic [$clog2(2*MAX_EDGES)-1:0]     nbr_waddr,
    input  logic [$clog2(MAX_NODES)-1:0]       nbr_wdata,
    input  logic [$clog2(2*MAX_EDGES)-1:0]     link_waddr,
    input  logic [$clog2(2*MAX_EDGES+1)-1:0]   link_wdata,
    output logic [$clog2(MAX_NODES)-1:0]       nbr_rd,
    output logic [$clog2(2*MAX_EDGES+1)-1:0]   link_rd
);
    import gdfs_pkg::*;

    localparam int SLOTS = 2 * MAX_EDGES;
    localparam int LW    = $clog2(SLOTS + 1);
    localparam int NW    = $clog2(MAX_NODES);

    logic [2*LW-1:0]      list_mem_reg [MAX_NODES];
    logic [2*LW-1:0]      list_rd_reg;
    logic [MAX_NODES-1:0] list_vld_reg;
    logic                 list_vld_rd_reg;
    logic [NW-1:0]        nbr_mem_reg [SLOTS];
    logic [LW-1:0]        link_mem_reg [SLOTS];
    logic [NW-1:0]        nbr_rd_reg;
    logic [LW-1:0]        link_rd_reg;

    // List valid bits: an entry that is not valid reads as an empty list.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.list_clear) begin
            list_vld_reg <= '0;
        end else if (ctrl.list_we) begin
            list_vld_reg[list_waddr] <= 1'b1;
        end
    end

    // Head and tail memory with a registered read.
    always_ff @(posedge aclk) begin
        if (ctrl.list_we) begin
            list_mem_reg[list_waddr] <= {list_wfirst, list_wlast};
        end
        list_rd_reg     <= list_mem_reg[list_raddr];
        list_vld_rd_reg <= list_vld_reg[list_raddr];
    end

    // Link slot memories, one write and one read port each.
    always_ff @(posedge aclk) begin
        if (ctrl.nbr_we) begin
            nbr_mem_reg[nbr_waddr] <= nbr_wdata;
        end
        if (ctrl.link_we) begin
            link_mem_reg[link_waddr] <= link_wdata;
        end
        nbr_rd_reg  <= nbr_mem_reg[slot_raddr];
        link_rd_reg <= link_mem_reg[slot_raddr];
    end

    assign list_rd_valid = list_vld_rd_reg;
    assign list_rd_first = list_rd_reg[2*LW-1:LW];
    assign list_rd_last  = list_rd_reg[LW-1:0];
    assign nbr_rd        = nbr_rd_reg;
    assign link_rd       = link_rd_reg;

endmodule

`default_nettype wire

// ===== rtl/graph_dfs_timestamps.sv =====
// Edge word: accepted when idle, then APP_RD, APP_WR, APP_LINK run for each end; next word taken in idle.
// Run word: walk and report are paced by the single-ported adjacency and stack memories; each result
// then waits on m_ready.
// Reset: sequencer idle, lists empty, counters cleared, node_count set to 64.
// No clearing pass: list valid bits and visited marks clear together when the last report word is taken.
// ----------------------------------------------------------------------------
// graph_dfs_timestamps
// Loads an undirected graph edge by edge and, on a run word, walks it depth
// first with an explicit stack, stamping entry and exit times per node.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_dfs_timestamps #(
    parameter int MAX_NODES = gdfs_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = gdfs_pkg::DEF_MAX_EDGES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [gdfs_pkg::COUNT_W-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [gdfs_pkg::NODE_W-1:0]   s_node_a,
    input  logic [gdfs_pkg::NODE_W-1:0]   s_node_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gdfs_pkg::NODE_W-1:0]   m_node_index,
    output logic [gdfs_pkg::TIME_W-1:0]   m_entry_time,
    output logic [gdfs_pkg::TIME_W-1:0]   m_exit_time,
    output logic                          m_last,
    output logic                          m_edges_dropped
);
    import gdfs_pkg::*;

    localparam int SLOTS = 2 * MAX_EDGES;
    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = $clog2(SLOTS + 1);
    localparam int NW    = $clog2(MAX_NODES);
    localparam int DW    = $clog2(MAX_NODES + 1);
    localparam int LIMIT = (MAX_NODES < ID_LIMIT) ? MAX_NODES : ID_LIMIT;
    localparam logic [LW-1:0] LINK_NULL = LW'(SLOTS);

    // Control registers.
    gdfs_state_t          state_reg, state_next;
    logic [COUNT_W-1:0]   node_count_reg, node_count_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [LW-1:0]        slots_reg, slots_next;
    logic                 ovf_reg, ovf_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [DW-1:0]        depth_reg, depth_next;
    logic [COUNT_W-1:0]   sweep_reg, sweep_next;
    logic                 second_reg, second_next;
    logic                 m_valid_reg, m_valid_next;

    // Working registers.
    logic [NW-1:0]        a_reg, a_next;
    logic [NW-1:0]        b_reg, b_next;
    logic [NODE_W-1:0]    start_reg, start_next;
    logic [NW-1:0]        v_reg, v_next;
    logic [NW-1:0]        top_node_reg, top_node_next;
    logic [LW-1:0]        top_cur_reg, top_cur_next;
    logic [LW-1:0]        prev_last_reg, prev_last_next;
    logic                 had_reg, had_next;
    logic [NODE_W-1:0]    m_node_reg, m_node_next;
    logic [TIME_W-1:0]    m_entry_reg, m_entry_next;
    logic [TIME_W-1:0]    m_exit_reg, m_exit_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_drop_reg, m_drop_next;

    // Stamp and stack memories.
    logic [TIME_W-1:0]    entry_mem_reg [MAX_NODES];
    logic [TIME_W-1:0]    exit_mem_reg [MAX_NODES];
    logic [NW+LW-1:0]     stack_mem_reg [MAX_NODES];
    logic [TIME_W-1:0]    entry_rd_reg;
    logic [TIME_W-1:0]    exit_rd_reg;
    logic [NW+LW-1:0]     stack_rd_reg;

    // Combinational controls.
    gdfs_adj_ctrl_t       adj_ctrl;
    logic [NW-1:0]        owner, other;
    logic [NW-1:0]        list_raddr;
    logic [LW-1:0]        list_wfirst;
    logic                 list_rd_valid;
    logic [LW-1:0]        list_rd_first, list_rd_last;
    logic [SW-1:0]        link_waddr;
    logic [LW-1:0]        link_wdata;
    logic [NW-1:0]        nbr_rd;
    logic [LW-1:0]        link_rd;
    logic                 enter_go;
    logic [NW-1:0]        enter_node;
    logic                 exit_we;
    logic                 stack_we;
    logic [COUNT_W-1:0]   count_sat;

    assign owner = second_reg ? b_reg : a_reg;
    assign other = second_reg ? a_reg : b_reg;

    // Node count saturated to the range the walk supports.
    assign count_sat = (node_count_reg == '0) ? COUNT_W'(1) :
                       (32'(node_count_reg) > LIMIT) ? COUNT_W'(LIMIT) : node_count_reg;

    gdfs_adj #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_adj (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (adj_ctrl),
        .list_raddr    (list_raddr),
        .list_waddr    (owner),
        .list_wfirst   (list_wfirst),
        .list_wlast    (slots_reg),
        .list_rd_valid (list_rd_valid),
        .list_rd_first (list_rd_first),
        .list_rd_last  (list_rd_last),
        .slot_raddr    (SW'(top_cur_reg)),
        .nbr_waddr     (SW'(slots_reg)),
        .nbr_wdata     (other),
        .link_waddr    (link_waddr),
        .link_wdata    (link_wdata),
        .nbr_rd        (nbr_rd),
        .link_rd       (link_rd)
    );

    // Control state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NODE_COUNT_RST;
            count_reg      <= COUNT_W'(1);
            slots_reg      <= '0;
            ovf_reg        <= 1'b0;
            time_reg       <= '0;
            visited_reg    <= '0;
            depth_reg      <= '0;
            sweep_reg      <= '0;
            second_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            count_reg      <= count_next;
            slots_reg      <= slots_next;
            ovf_reg        <= ovf_next;
            time_reg       <= time_next;
            visited_reg    <= visited_next;
            depth_reg      <= depth_next;
            sweep_reg      <= sweep_next;
            second_reg     <= second_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Working and result registers need no reset.
    always_ff @(posedge aclk) begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        start_reg     <= start_next;
        v_reg         <= v_next;
        top_node_reg  <= top_node_next;
        top_cur_reg   <= top_cur_next;
        prev_last_reg <= prev_last_next;
        had_reg       <= had_next;
        m_node_reg    <= m_node_next;
        m_entry_reg   <= m_entry_next;
        m_exit_reg    <= m_exit_next;
        m_last_reg    <= m_last_next;
        m_drop_reg    <= m_drop_next;
    end

    // Stamp memories: written on entry and exit, read while reporting.
    always_ff @(posedge aclk) begin
        if (enter_go) begin
            entry_mem_reg[enter_node] <= time_reg;
        end
        if (exit_we) begin
            exit_mem_reg[top_node_reg] <= time_reg;
        end
        entry_rd_reg <= entry_mem_reg[NW'(sweep_reg)];
        exit_rd_reg  <= exit_mem_reg[NW'(sweep_reg)];
    end

    // Stack memory holds every level below the top, which lives in registers.
    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem_reg[NW'(depth_reg - DW'(1))] <= {top_node_reg, top_cur_reg};
        end
        stack_rd_reg <= stack_mem_reg[NW'(depth_reg - DW'(2))];
    end

    // Sequencer: next state and datapath controls.
    always_comb begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        count_next      = count_reg;
        slots_next      = slots_reg;
        ovf_next        = ovf_reg;
        time_next       = time_reg;
        visited_next    = visited_reg;
        depth_next      = depth_reg;
        sweep_next      = sweep_reg;
        second_next     = second_reg;
        m_valid_next    = m_valid_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        start_next      = start_reg;
        v_next          = v_reg;
        top_node_next   = top_node_reg;
        top_cur_next    = top_cur_reg;
        prev_last_next  = prev_last_reg;
        had_next        = had_reg;
        m_node_next     = m_node_reg;
        m_entry_next    = m_entry_reg;
        m_exit_next     = m_exit_reg;
        m_last_next     = m_last_reg;
        m_drop_next     = m_drop_reg;
        adj_ctrl        = '0;
        list_raddr      = owner;
        list_wfirst     = list_rd_valid ? list_rd_first : slots_reg;
        link_waddr      = SW'(slots_reg);
        link_wdata      = LINK_NULL;
        enter_go        = 1'b0;
        enter_node      = v_reg;
        exit_we         = 1'b0;
        stack_we        = 1'b0;
        s_ready         = 1'b0;

        // The user must write the register only while the block is idle; the block itself does not enforce it.
        if (cfg_we) begin
            node_count_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == FUNC_RUN) begin
                        count_next = count_sat;
                        start_next = s_node_a;
                        sweep_next = '0;
                        state_next = ST_RUN_START;
                    end else if ((32'(s_node_a) < MAX_NODES) &&
                                 (32'(s_node_b) < MAX_NODES)) begin
                        if (32'(slots_reg) + 2 > SLOTS) begin
                            ovf_next = 1'b1;
                        end else begin
                            a_next      = NW'(s_node_a);
                            b_next      = NW'(s_node_b);
                            second_next = 1'b0;
                            state_next  = ST_APP_RD;
                        end
                    end
                end
            end

            // Tail of the owner's list is being read.
            ST_APP_RD: begin
                state_next = ST_APP_WR;
            end

            // New slot gets the neighbour and a null link; the list tail moves to it.
            ST_APP_WR: begin
                adj_ctrl.list_we = 1'b1;
                adj_ctrl.nbr_we  = 1'b1;
                adj_ctrl.link_we = 1'b1;
                prev_last_next   = list_rd_last;
                had_next         = list_rd_valid;
                state_next       = ST_APP_LINK;
            end

            // The old tail slot is chained to the new one.
            ST_APP_LINK: begin
                link_waddr       = SW'(prev_last_reg);
                link_wdata       = slots_reg;
                adj_ctrl.link_we = had_reg;
                slots_next       = slots_reg + LW'(1);
                if (second_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    second_next = 1'b1;
                    state_next  = ST_APP_RD;
                end
            end

            ST_RUN_START: begin
                if (7'(start_reg) < count_reg) begin
                    enter_go   = 1'b1;
                    enter_node = NW'(start_reg);
                end else begin
                    state_next = ST_SWEEP;
                end
            end

            // Ascending sweep starts a walk from every unvisited node.
            ST_SWEEP: begin
                if (sweep_reg == count_reg) begin
                    sweep_next = '0;
                    state_next = ST_REP_RD;
                end else if (!visited_reg[NW'(sweep_reg)]) begin
                    enter_go   = 1'b1;
                    enter_node = NW'(sweep_reg);
                end else begin
                    sweep_next = sweep_reg + COUNT_W'(1);
                end
            end

            // Push the entered node with the head of its list as cursor.
            ST_PUSH: begin
                stack_we      = (depth_reg != '0);
                top_node_next = v_reg;
                top_cur_next  = list_rd_valid ? list_rd_first : LINK_NULL;
                depth_next    = depth_reg + DW'(1);
                state_next    = ST_STEP;
            end

            // Either finish the top node or fetch its next neighbour.
            ST_STEP: begin
                if (top_cur_reg == LINK_NULL) begin
                    exit_we    = 1'b1;
                    time_next  = time_reg + TIME_W'(1);
                    depth_next = depth_reg - DW'(1);
                    if (depth_reg > DW'(1)) begin
                        state_next = ST_POP;
                    end else begin
                        state_next = ST_SWEEP;
                    end
                end else begin
                    state_next = ST_NBR;
                end
            end

            // Advance the cursor and descend into an unvisited neighbour.
            ST_NBR: begin
                top_cur_next = link_rd;
                if ((32'(nbr_rd) < 32'(count_reg)) && !visited_reg[nbr_rd]) begin
                    enter_go   = 1'b1;
                    enter_node = nbr_rd;
                end else begin
                    state_next = ST_STEP;
                end
            end

            ST_POP: begin
                top_node_next = stack_rd_reg[NW+LW-1:LW];
                top_cur_next  = stack_rd_reg[LW-1:0];
                state_next    = ST_STEP;
            end

            ST_REP_RD: begin
                state_next = ST_REP_LOAD;
            end

            ST_REP_LOAD: begin
                m_valid_next = 1'b1;
                m_node_next  = NODE_W'(sweep_reg);
                m_entry_next = entry_rd_reg;
                m_exit_next  = exit_rd_reg;
                m_last_next  = ((sweep_reg + COUNT_W'(1)) == count_reg);
                m_drop_next  = ovf_reg;
                state_next   = ST_REP_WAIT;
            end

            // After the final word is taken the graph is cleared.
            ST_REP_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        visited_next        = '0;
                        adj_ctrl.list_clear = 1'b1;
                        slots_next          = '0;
                        time_next           = '0;
                        ovf_next            = 1'b0;
                        depth_next          = '0;
                        state_next          = ST_IDLE;
                    end else begin
                        sweep_next = sweep_reg + COUNT_W'(1);
                        state_next = ST_REP_RD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Entering a node: mark, stamp, count and fetch its list head.
        if (enter_go) begin
            visited_next[enter_node] = 1'b1;
            time_next                = time_reg + TIME_W'(1);
            list_raddr               = enter_node;
            v_next                   = enter_node;
            state_next               = ST_PUSH;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_node_index    = m_node_reg;
    assign m_entry_time    = m_entry_reg;
    assign m_exit_time     = m_exit_reg;
    assign m_last          = m_last_reg;
    assign m_edges_dropped = m_drop_reg;

endmodule

`default_nettype wire

// ===== rtl/gdfs_check.sv =====
// ----------------------------------------------------------------------------
// gdfs_check
// Port-level checks on the walk block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "graph_dfs_timestamps_macros.svh"

module gdfs_check (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_func,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [gdfs_pkg::NODE_W-1:0]   m_node_index,
    input  logic [gdfs_pkg::TIME_W-1:0]   m_entry_time,
    input  logic [gdfs_pkg::TIME_W-1:0]   m_exit_time,
    input  logic                          m_last
);
    import gdfs_pkg::*;

    // A report word never shares a cycle with a free input side.
    `GDFS_ASSERT_ALWAYS(a_busy_while_reporting, aclk, aresetn, !(s_ready && m_valid), "input ready during report")

    // A node is entered and left at different counter values.
    `GDFS_ASSERT_ALWAYS(a_stamps_differ, aclk, aresetn, !m_valid || (m_entry_time != m_exit_time), "entry and exit stamps equal")

    // A run word takes the block out of the idle state.
    `GDFS_ASSERT_NEXT(a_run_goes_busy, aclk, aresetn, s_valid && s_ready && (s_func == FUNC_RUN), !s_ready, "ready straight after a run word")

    // More report words follow until the last one is taken.
    `GDFS_ASSERT_NEXT(a_report_continues, aclk, aresetn, m_valid && m_ready && !m_last, !s_ready, "input ready before the last word")

    // A stalled report word holds its node index.
    `GDFS_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_node_index), "stalled word changed")

endmodule

bind graph_dfs_timestamps gdfs_check u_gdfs_check (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_func       (s_func),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_node_index (m_node_index),
    .m_entry_time (m_entry_time),
    .m_exit_time  (m_exit_time),
    .m_last       (m_last)
);

`default_nettype wire

// ===== tb/sv/graph_dfs_timestamps_test.sv =====
// ----------------------------------------------------------------------------
// graph_dfs_timestamps_test
// Self-checking bench for the depth-first walk block. Edge words build small
// graphs and run words walk them. A scoreboard keeps its own copy of the
// neighbour lists, walks it with an explicit stack, and checks each stamp
// word against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module graph_dfs_timestamps_test;
    import gdfs_pkg::*;

    localparam int SLOT_COUNT    = 2 * DEF_MAX_EDGES;
    localparam int LINK_END      = SLOT_COUNT;
    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_WORDS  = 150;
    localparam int IDLE_PERCENT  = 19;

    // One stamp word as the block reports it.
    typedef struct packed {
        logic [NODE_W-1:0] node_index;
        logic [TIME_W-1:0] entry_stamp;
        logic [TIME_W-1:0] exit_stamp;
        logic              last;
        logic              dropped;
    } stamp_t;

    // Scoreboard: mirrors the graph store and predicts the stamps of a run.
    class dfs_scoreboard;
        logic [COUNT_W-1:0] node_count;
        int                 first_slot [DEF_MAX_NODES];
        int                 last_slot  [DEF_MAX_NODES];
        int                 next_slot  [SLOT_COUNT];
        int                 nbr_of     [SLOT_COUNT];
        int                 slots_used;
        bit                 visited    [DEF_MAX_NODES];
        logic [TIME_W-1:0]  entry_at   [DEF_MAX_NODES];
        logic [TIME_W-1:0]  exit_at    [DEF_MAX_NODES];
        logic [TIME_W-1:0]  clock_now;
        int                 stk_node   [DEF_MAX_NODES];
        int                 stk_cur    [DEF_MAX_NODES];
        int                 depth;
        bit                 dropped;
        stamp_t             stamps_due [$];
        int                 errors;
        int                 edges_seen;
        int                 runs_seen;
        int                 stamps_checked;
        bit                 any_dropped;

        function new();
            node_count = NODE_COUNT_RST;
            errors = 0;
            edges_seen = 0;
            runs_seen = 0;
            stamps_checked = 0;
            any_dropped = 0;
            clear_graph();
        endfunction

        // Lists, marks, counter and overflow flag all go back to empty.
        function void clear_graph();
            for (int i = 0; i < DEF_MAX_NODES; i++) begin
                first_slot[i] = LINK_END;
                last_slot[i] = LINK_END;
                visited[i] = 1'b0;
            end
            slots_used = 0;
            clock_now = '0;
            depth = 0;
            dropped = 1'b0;
        endfunction

        // Node count in use: a zero acts as one, and large values saturate.
        function int live_nodes();
            int lim;
            int cnt;
            lim = (DEF_MAX_NODES < ID_LIMIT) ? DEF_MAX_NODES : ID_LIMIT;
            cnt = int'(node_count);
            if (cnt < 1) cnt = 1;
            if (cnt > lim) cnt = lim;
            return cnt;
        endfunction

        // Append one neighbour to the tail of the owner's list.
        function void link_slot(int owner, int nb);
            int s;
            s = slots_used;
            slots_used++;
            nbr_of[s] = nb;
            next_slot[s] = LINK_END;
            if (last_slot[owner] == LINK_END) first_slot[owner] = s;
            else next_slot[last_slot[owner]] = s;
            last_slot[owner] = s;
        endfunction

        // Stamp the entry of a node and push it with its list head.
        function void mark_entry(int v);
            visited[v] = 1'b1;
            entry_at[v] = clock_now;
            clock_now = clock_now + 1'b1;
            if (depth < DEF_MAX_NODES) begin
                stk_node[depth] = v;
                stk_cur[depth] = first_slot[v];
                depth++;
            end
        endfunction

        // Walk one component from its root until the stack is empty.
        function void walk_component(int root, int cnt);
            int top;
            int cur;
            int nb;
            mark_entry(root);
            while (depth > 0) begin
                top = depth - 1;
                cur = stk_cur[top];
                if (cur >= LINK_END) begin
                    exit_at[stk_node[top]] = clock_now;
                    clock_now = clock_now + 1'b1;
                    depth = top;
                end else begin
                    nb = nbr_of[cur];
                    stk_cur[top] = next_slot[cur];
                    if (nb < cnt && !visited[nb]) mark_entry(nb);
                end
            end
        endfunction

        // An accepted input word: load an edge or run the walk.
        function void note_word(logic func, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
            int cnt;
            stamp_t st;
            if (func == FUNC_EDGE) begin
                edges_seen++;
                if (int'(a) >= DEF_MAX_NODES || int'(b) >= DEF_MAX_NODES) return;
                if (slots_used + 2 > SLOT_COUNT) begin
                    dropped = 1'b1;
                    return;
                end
                link_slot(a, b);
                link_slot(b, a);
            end else begin
                runs_seen++;
                cnt = live_nodes();
                if (int'(a) < cnt && !visited[a]) walk_component(a, cnt);
                for (int i = 0; i < cnt; i++)
                    if (!visited[i]) walk_component(i, cnt);
                for (int i = 0; i < cnt; i++) begin
                    st.node_index = NODE_W'(i);
                    st.entry_stamp = entry_at[i];
                    st.exit_stamp = exit_at[i];
                    st.last = (i == cnt - 1);
                    st.dropped = dropped;
                    stamps_due.push_back(st);
                end
                if (dropped) any_dropped = 1'b1;
                clear_graph();
            end
        endfunction

        // Print one line per mismatch, up to a cap, and count them all.
        function void report(string msg);
            errors++;
            if (errors <= 40) $display("ERROR at %0t: %s", $realtime, msg);
        endfunction

        function void check_field(string name, int node, int got, int want);
            if (got != want)
                report($sformatf("node %0d %s: got %0d, expected %0d", node, name, got, want));
        endfunction

        // A received stamp word against the oldest prediction.
        function void check_result(stamp_t got);
            stamp_t want;
            if (stamps_due.size() == 0) begin
                report($sformatf("unexpected stamp word for node %0d", got.node_index));
                return;
            end
            want = stamps_due.pop_front();
            stamps_checked++;
            check_field("node_index", want.node_index, got.node_index, want.node_index);
            check_field("entry_time", want.node_index, got.entry_stamp, want.entry_stamp);
            check_field("exit_time", want.node_index, got.exit_stamp, want.exit_stamp);
            check_field("last", want.node_index, got.last, want.last);
            check_field("edges_dropped", want.node_index, got.dropped, want.dropped);
        endfunction
    endclass

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                cfg_we          = 1'b0;
    logic [COUNT_W-1:0]  cfg_wdata       = '0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic                s_func          = FUNC_EDGE;
    logic [NODE_W-1:0]   s_node_a        = '0;
    logic [NODE_W-1:0]   s_node_b        = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [NODE_W-1:0]   m_node_index;
    logic [TIME_W-1:0]   m_entry_time;
    logic [TIME_W-1:0]   m_exit_time;
    logic                m_last;
    logic                m_edges_dropped;

    dfs_scoreboard       sb;
    bit                  steady          = 1'b0;
    int                  words_sent      = 0;
    int                  quiet_cycles    = 0;

    graph_dfs_timestamps u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_node_a        (s_node_a),
        .s_node_b        (s_node_b),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_node_index    (m_node_index),
        .m_entry_time    (m_entry_time),
        .m_exit_time     (m_exit_time),
        .m_last          (m_last),
        .m_edges_dropped (m_edges_dropped)
    );

    // Clock with a period of ten units.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side back-pressure, switched off during the steady stretch.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Monitor both channels and watch for a stalled run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_word(s_func, s_node_a, s_node_b);
            if (m_valid && m_ready)
                sb.check_result('{m_node_index, m_entry_time, m_exit_time,
                                  m_last, m_edges_dropped});
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("Timed out after %0d cycles with no word moving", QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offer one input word, with random idle cycles ahead of it outside the steady stretch.
    task automatic send_word(input logic func, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_node_a <= a;
        s_node_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    // Drain every pending stamp, let a trailing edge load finish, then
    // write the node count while the block is idle. The first edge lets the
    // monitor note a word taken at the edge just passed.
    task automatic set_count_when_idle(input logic [COUNT_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.stamps_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.node_count = value;
    endtask

    // A random node count, a handful of edges mostly inside it, then a run.
    task automatic random_graph(input bit calm);
        int pick;
        int span;
        int n_edges;
        logic [COUNT_W-1:0] cnt_value;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        pick = $urandom_range(99);
        if (pick < 10) cnt_value = '0;
        else if (pick < 20) cnt_value = COUNT_W'($urandom_range(127, 65));
        else if (pick < 30) cnt_value = NODE_COUNT_RST;
        else cnt_value = COUNT_W'($urandom_range(16, 1));
        set_count_when_idle(cnt_value);
        steady = calm;
        span = sb.live_nodes();
        n_edges = $urandom_range(20, 0);
        for (int i = 0; i < n_edges; i++) begin
            a = ($urandom_range(99) < 85) ? NODE_W'($urandom_range(span - 1, 0))
                                          : NODE_W'($urandom_range(63, 0));
            b = ($urandom_range(99) < 85) ? NODE_W'($urandom_range(span - 1, 0))
                                          : NODE_W'($urandom_range(63, 0));
            send_word(FUNC_EDGE, a, b);
        end
        a = ($urandom_range(99) < 90) ? NODE_W'($urandom_range(span - 1, 0))
                                      : NODE_W'($urandom_range(63, 0));
        send_word(FUNC_RUN, a, NODE_W'($urandom));
    endtask

    initial begin
        int graphs;
        int first_random;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty graph at the reset node count, started from the top node.
        send_word(FUNC_RUN, 6'd63, 6'd0);

        // Duplicate edges, a self-loop, a triangle, and alternating bit patterns.
        send_word(FUNC_EDGE, 6'd0, 6'd63);
        send_word(FUNC_EDGE, 6'd63, 6'd63);
        send_word(FUNC_EDGE, 6'd0, 6'd63);
        send_word(FUNC_EDGE, 6'd5, 6'd6);
        send_word(FUNC_EDGE, 6'd6, 6'd7);
        send_word(FUNC_EDGE, 6'd7, 6'd5);
        send_word(FUNC_EDGE, 6'd42, 6'd21);
        send_word(FUNC_RUN, 6'd5, 6'd63);

        // Three nodes: neighbours beyond the count and a start node beyond it.
        set_count_when_idle(7'd3);
        send_word(FUNC_EDGE, 6'd1, 6'd2);
        send_word(FUNC_EDGE, 6'd2, 6'd40);
        send_word(FUNC_EDGE, 6'd40, 6'd41);
        send_word(FUNC_EDGE, 6'd0, 6'd0);
        send_word(FUNC_RUN, 6'd50, 6'd21);

        // A zero count behaves as a single node.
        set_count_when_idle(7'd0);
        send_word(FUNC_EDGE, 6'd0, 6'd0);
        send_word(FUNC_RUN, 6'd0, 6'd0);

        // The widest register value saturates to the full node range.
        set_count_when_idle(7'd127);
        send_word(FUNC_EDGE, 6'd63, 6'd0);
        send_word(FUNC_EDGE, 6'd31, 6'd32);
        send_word(FUNC_RUN, 6'd62, 6'd42);

        // One node with an out-of-range start, then two nodes joined.
        set_count_when_idle(7'd1);
        send_word(FUNC_RUN, 6'd63, 6'd63);
        set_count_when_idle(7'd2);
        send_word(FUNC_EDGE, 6'd1, 6'd0);
        send_word(FUNC_RUN, 6'd1, 6'd0);

        // Random graphs; one of them runs with no idling on either side.
        graphs = 0;
        first_random = words_sent;
        while (words_sent - first_random < RANDOM_WORDS) begin
            random_graph(graphs == 4);
            graphs++;
        end

        // Fill the link store past capacity so the last edges are dropped.
        set_count_when_idle(NODE_COUNT_RST);
        steady = 1'b0;
        for (int i = 0; i < DEF_MAX_EDGES + 4; i++)
            send_word(FUNC_EDGE, NODE_W'($urandom_range(63, 0)),
                      NODE_W'($urandom_range(63, 0)));
        send_word(FUNC_RUN, NODE_W'($urandom_range(63, 0)), 6'd0);

        // The overflow flag must be clear again on the next graph.
        set_count_when_idle(7'd5);
        send_word(FUNC_EDGE, 6'd3, 6'd4);
        send_word(FUNC_RUN, 6'd4, 6'd0);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.stamps_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d edge words and %0d walks, %0d stamp words checked.",
                 sb.edges_seen, sb.runs_seen, sb.stamps_checked);
        $display("Random graphs: %0d; capacity overflow reached: %0d.",
                 graphs, sb.any_dropped);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
